// ===== sv/irsf_pkg.sv =====
// Shared constants for the IR sensor filter and normalizer.
// Command codes, field widths and parameter defaults; no dependencies.
`default_nettype none

package irsf_pkg;

	// commands carried in s_tuser
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_PRIME  = 2'd1;
	localparam logic [1:0] CMD_RECAL  = 2'd2;

	// parameter defaults
	localparam int CHANNELS_DEF    = 6;
	localparam int WINDOW_DEF      = 8;
	localparam int SAMPLE_BITS_DEF = 10;

	// field widths
	localparam int CMD_W       = 2;
	localparam int CH_W        = 3;
	localparam int SMP_W       = 10;
	localparam int LVL_W       = 10;
	localparam int LED_W       = 6;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (CH_W + 4 * LVL_W + LED_W);

	// normalization full scale and threshold reset value
	localparam int NORM_BITS = 10;
	localparam int NORM_FULL = 1000;
	localparam logic [LVL_W-1:0] THR_RESET = 10'd800;

endpackage

`default_nettype wire

// ===== sv/ir_sensor_filter_normalizer.sv =====
// IR sensor moving-average filter with min/max normalization.
// Depends on irsf_pkg (command codes, widths, defaults).
//
// Input stream s_*: one request per item. s_tuser = command, s_tdata = channel, sample.
// Output stream m_*: exactly one result per request, held in an output register.
// Config: cfg_we/cfg_wdata write the LED threshold (reset 800); write only when idle.
//
// The per-channel sample windows live in one synchronous RAM (CHANNELS*WINDOW entries,
// registered read). A sample reads the oldest entry, updates the running sum and writes
// the new sample back to the same entry; only one item is in flight.
// Steps from the accepting edge to the edge that loads the result:
//   sample: RAM read, sum update, reciprocal multiply of the average when the window is
//           not a power of two, min/max update, then the restoring divider for the norm,
//           skipped when min equals max.
//   prime: RAM row fill, one entry a cycle.
//   recalibrate, undefined command, channel out of range: straight to the result.
// s_tready is high only in idle, which the sequencer enters when the result is loaded.
// Reset: a clearing pass writes zero to every RAM entry; s_tready stays low during it.
// If m_tready is low, a finished result waits in the output register and the next
// result is held until it is free.
`default_nettype none

module ir_sensor_filter_normalizer #(
	parameter int CHANNELS    = irsf_pkg::CHANNELS_DEF,
	parameter int WINDOW      = irsf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = irsf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [irsf_pkg::LVL_W-1:0]        cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [2:0] channel, [12:3] sample
	input  wire logic [irsf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [1:0] command
	input  wire logic [irsf_pkg::CMD_W-1:0]        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [2:0] channel_out, [12:3] filtered, [22:13] min_level, [32:23] max_level,
	// [42:33] norm, [48:43] led_mask
	output logic [irsf_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	localparam int SB       = SAMPLE_BITS;
	localparam int NB       = irsf_pkg::NORM_BITS;
	localparam int PW       = $clog2(WINDOW);
	localparam int SUMW     = SB + PW;
	localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW       = (SB > NB) ? SB : NB;
	localparam int WB       = $clog2(WINDOW + 1);
	localparam int DVW      = (SB > WB) ? SB : WB;
	localparam int NW       = DVW + QW;
	localparam int DCW      = $clog2(QW + 1);
	localparam int PRODW    = SB + NB;
	localparam bit WIN_POW2 = ((WINDOW & (WINDOW - 1)) == 0);
	// average by reciprocal multiply when the window is not a power of two
	localparam int AVG_SH   = SUMW + PW;
	localparam int APW      = 2 * SUMW + 1;
	localparam logic [APW-1:0] AVG_RCP =
		APW'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_PRIME  = 4'd2;
	localparam logic [3:0] ST_READ   = 4'd3;
	localparam logic [3:0] ST_UPDATE = 4'd4;
	localparam logic [3:0] ST_DIVF   = 4'd5;
	localparam logic [3:0] ST_LEVEL  = 4'd6;
	localparam logic [3:0] ST_NORM   = 4'd7;
	localparam logic [3:0] ST_DIVN   = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	// window RAM
	logic [SB-1:0]   win_mem [DEPTH];
	logic [SB-1:0]   mem_rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	logic [SB-1:0]   mem_wdata;

	// per-channel state
	logic [SUMW-1:0] sum_q  [CHANNELS];
	logic [PW-1:0]   pos_q  [CHANNELS];
	logic [SB-1:0]   filt_q [CHANNELS];
	logic [SB-1:0]   min_q  [CHANNELS];
	logic [SB-1:0]   max_q  [CHANNELS];
	logic [CHANNELS-1:0] led_q;
	logic [irsf_pkg::LVL_W-1:0] thr_q;

	// sequencer
	logic [3:0]      state_q;
	logic [AW-1:0]   clr_cnt_q;
	logic [PW-1:0]   prime_cnt_q;
	logic [1:0]      cmd_q;
	logic [irsf_pkg::CH_W-1:0] ch_q;
	logic [SB-1:0]   v_q;
	logic [SB-1:0]   f_q;
	logic [PRODW-1:0] prod_q;
	logic [SB-1:0]   span_q;
	logic [NB-1:0]   norm_q;

	// restoring divider for the normalization
	logic [DVW-1:0]  div_rem_q;
	logic [QW-1:0]   div_low_q;
	logic [QW-1:0]   div_quo_q;
	logic [DVW-1:0]  div_den_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [DVW:0]    div_shift;
	logic [DVW:0]    div_diff;
	logic            div_ge;

	logic [irsf_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic            m_tvalid_q;

	logic [irsf_pkg::CH_W-1:0] in_ch;
	logic [CW-1:0]   in_chi;
	logic            in_ok;
	logic [SB-1:0]   in_v;
	logic [CW-1:0]   chi;
	logic            ch_ok;
	logic [AW-1:0]   row_base;
	logic [PW-1:0]   pos_cur;
	logic [SUMW-1:0] new_sum;
	logic [APW-1:0]  avg_prod;
	logic [SB-1:0]   lvl_lo;
	logic [SB-1:0]   lvl_hi;
	logic [CHANNELS-1:0] led_next;
	logic [NW-1:0]   div_n_num;

	assign in_ch  = s_tdata[irsf_pkg::CH_W-1:0];
	assign in_chi = CW'(in_ch);
	assign in_ok  = (32'(in_ch) < CHANNELS);
	assign in_v   = SB'(s_tdata[irsf_pkg::CH_W +: irsf_pkg::SMP_W]);

	assign chi      = CW'(ch_q);
	assign ch_ok    = (32'(ch_q) < CHANNELS);
	assign row_base = AW'(32'(chi) * WINDOW);
	assign pos_cur  = ch_ok ? pos_q[chi] : '0;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		mem_raddr = row_base + AW'(pos_cur);
		mem_we    = 1'b0;
		mem_waddr = mem_raddr;
		mem_wdata = v_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_PRIME: begin
				mem_we    = 1'b1;
				mem_waddr = row_base + AW'(prime_cnt_q);
			end
			ST_UPDATE: begin
				mem_we = ch_ok;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= win_mem[mem_raddr];
	end

	always_comb begin
		new_sum  = '0;
		avg_prod = '0;
		lvl_lo   = f_q;
		lvl_hi   = f_q;
		if (ch_ok) begin
			new_sum  = sum_q[chi] - SUMW'(mem_rdata_q) + SUMW'(v_q);
			avg_prod = APW'(sum_q[chi]) * AVG_RCP;
			lvl_lo   = (f_q < min_q[chi]) ? f_q : min_q[chi];
			lvl_hi   = (f_q > max_q[chi]) ? f_q : max_q[chi];
		end
	end

	assign div_n_num = NW'(prod_q);
	assign div_shift = {div_rem_q, div_low_q[QW-1]};
	assign div_diff  = div_shift - {1'b0, div_den_q};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});

	always_comb begin
		led_next = led_q;
		if (cmd_q == irsf_pkg::CMD_RECAL) begin
			led_next = {CHANNELS{thr_q == '0}};
		end else if (ch_ok && (cmd_q == irsf_pkg::CMD_SAMPLE ||
				cmd_q == irsf_pkg::CMD_PRIME)) begin
			led_next[chi] = (norm_q >= thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			prime_cnt_q <= '0;
			div_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
			led_q       <= '0;
			thr_q       <= irsf_pkg::THR_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				pos_q[i]  <= '0;
				filt_q[i] <= '0;
				min_q[i]  <= '0;
				max_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (div_cnt_q != '0) begin
				div_rem_q <= div_ge ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
				div_low_q <= {div_low_q[QW-2:0], 1'b0};
				div_quo_q <= {div_quo_q[QW-2:0], div_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q  <= s_tuser;
						ch_q   <= in_ch;
						v_q    <= in_v;
						norm_q <= '0;
						if (s_tuser == irsf_pkg::CMD_RECAL) begin
							for (int i = 0; i < CHANNELS; i++) begin
								min_q[i] <= filt_q[i];
								max_q[i] <= filt_q[i];
							end
							state_q <= ST_DONE;
						end else if (in_ok && s_tuser == irsf_pkg::CMD_PRIME) begin
							sum_q[in_chi]  <= SUMW'(in_v) * SUMW'(WINDOW);
							pos_q[in_chi]  <= '0;
							filt_q[in_chi] <= in_v;
							min_q[in_chi]  <= in_v;
							max_q[in_chi]  <= in_v;
							prime_cnt_q    <= '0;
							state_q        <= ST_PRIME;
						end else if (in_ok && s_tuser == irsf_pkg::CMD_SAMPLE) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_PRIME: begin
					prime_cnt_q <= prime_cnt_q + 1'b1;
					if (prime_cnt_q == PW'(WINDOW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q[chi] <= new_sum;
					pos_q[chi] <= (pos_cur == PW'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;
					if (WIN_POW2) begin
						f_q     <= new_sum[SUMW-1:PW];
						state_q <= ST_LEVEL;
					end else begin
						state_q <= ST_DIVF;
					end
				end
				ST_DIVF: begin
					f_q     <= avg_prod[AVG_SH +: SB];
					state_q <= ST_LEVEL;
				end
				ST_LEVEL: begin
					filt_q[chi] <= f_q;
					min_q[chi]  <= lvl_lo;
					max_q[chi]  <= lvl_hi;
					prod_q      <= PRODW'(f_q - lvl_lo) * PRODW'(irsf_pkg::NORM_FULL);
					span_q      <= lvl_hi - lvl_lo;
					state_q     <= ST_NORM;
				end
				ST_NORM: begin
					if (span_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						div_rem_q <= div_n_num[NW-1:QW];
						div_low_q <= div_n_num[QW-1:0];
						div_den_q <= DVW'(span_q);
						div_cnt_q <= DCW'(QW);
						state_q   <= ST_DIVN;
					end
				end
				ST_DIVN: begin
					if (div_cnt_q == '0) begin
						norm_q  <= div_quo_q[NB-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						led_q      <= led_next;
						m_tvalid_q <= 1'b1;
						if (ch_ok) begin
							m_tdata_q <= {{irsf_pkg::OUT_PAD_W{1'b0}},
								irsf_pkg::LED_W'(led_next),
								irsf_pkg::LVL_W'(norm_q),
								irsf_pkg::LVL_W'(max_q[chi]),
								irsf_pkg::LVL_W'(min_q[chi]),
								irsf_pkg::LVL_W'(filt_q[chi]),
								ch_q};
						end else begin
							m_tdata_q <= {{irsf_pkg::OUT_PAD_W{1'b0}},
								irsf_pkg::LED_W'(led_next),
								{(4 * irsf_pkg::LVL_W){1'b0}},
								ch_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// divider never loaded beyond its quotient width
	assert property (@(posedge clk) disable iff (!arst_n) div_cnt_q <= DCW'(QW))
		else $error("divider step count out of range");

	// a result is loaded only from the completion state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside completion state");

	// filtered level stays inside the tracked range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ch_ok) |->
		(min_q[chi] <= filt_q[chi] && filt_q[chi] <= max_q[chi]))
		else $error("filtered level outside min/max");

	// normalized level never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[42:33] <= irsf_pkg::LVL_W'(irsf_pkg::NORM_FULL))
		else $error("norm above full scale");

	// no request taken while the window RAM is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!s_tready && !m_tvalid))
		else $error("activity during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== verif/ir_sensor_filter_normalizer_test.sv =====
// Self-checking bench for ir_sensor_filter_normalizer: random and directed sensor requests,
// per-channel moving-average / min-max predictor, scoreboard on the result stream.
// Depends on irsf_pkg and the ir_sensor_filter_normalizer RTL.
`timescale 1ns / 100ps

module ir_sensor_filter_normalizer_test;

	localparam int NCH          = irsf_pkg::CHANNELS_DEF;
	localparam int NWIN         = irsf_pkg::WINDOW_DEF;
	localparam int QUIET_LIMIT  = 3000;
	localparam int SETTLE_CYC   = 40;
	localparam int PHASE_ITEMS  = 356;
	localparam logic [1:0] CMD_UNDEF = 2'd3;

	typedef struct packed {
		logic                       wait_idle;  // hold off until every result is back
		logic [irsf_pkg::CMD_W-1:0] command;
		logic [irsf_pkg::CH_W-1:0]  channel;
		logic [irsf_pkg::SMP_W-1:0] sample;
	} sensor_req_t;

	typedef struct packed {
		logic [irsf_pkg::CH_W-1:0]  channel_out;
		logic [irsf_pkg::LVL_W-1:0] filtered;
		logic [irsf_pkg::LVL_W-1:0] min_level;
		logic [irsf_pkg::LVL_W-1:0] max_level;
		logic [irsf_pkg::LVL_W-1:0] norm;
		logic [irsf_pkg::LED_W-1:0] led_mask;
	} level_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [irsf_pkg::LVL_W-1:0]       cfg_wdata = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [irsf_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [irsf_pkg::CMD_W-1:0]       s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [irsf_pkg::OUT_TDATA_W-1:0] m_tdata;

	ir_sensor_filter_normalizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [irsf_pkg::SMP_W-1:0] win_mem [NCH][NWIN];
	logic [12:0]                win_total [NCH];
	logic [2:0]                 wr_ptr [NCH];
	logic [irsf_pkg::LVL_W-1:0] level [NCH];
	logic [irsf_pkg::LVL_W-1:0] lo_level [NCH];
	logic [irsf_pkg::LVL_W-1:0] hi_level [NCH];
	logic [irsf_pkg::LED_W-1:0] led_state = '0;
	logic [irsf_pkg::LVL_W-1:0] led_thr = irsf_pkg::THR_RESET;

	sensor_req_t   sensor_req_q[$];
	level_result_t expected_level_q[$];

	int mismatch_cnt = 0;
	int quiet_cycles = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit idle_on = 1'b1;
	int drift [NCH];

	sensor_req_t   req_now, req_head;
	level_result_t got_res, want_res;

	initial begin
		for (int c = 0; c < NCH; c++) begin
			win_total[c] = '0;
			wr_ptr[c]    = '0;
			level[c]     = '0;
			lo_level[c]  = '0;
			hi_level[c]  = '0;
			drift[c]     = 512;
			for (int w = 0; w < NWIN; w++)
				win_mem[c][w] = '0;
		end
	end

	function automatic logic [irsf_pkg::LVL_W-1:0] scale_level(int f, int lo, int hi);
		if (hi <= lo || f < lo)
			return '0;
		if (f > hi)
			f = hi;
		return irsf_pkg::LVL_W'(((f - lo) * irsf_pkg::NORM_FULL) / (hi - lo));
	endfunction

	function automatic level_result_t filter_normalize(sensor_req_t rq);
		level_result_t r;
		int ch, p, f, nrm, i;
		bit ok;
		ch  = rq.channel;
		ok  = ch < NCH;
		nrm = 0;
		if (rq.command == irsf_pkg::CMD_RECAL) begin
			for (i = 0; i < NCH; i++) begin
				lo_level[i]  = level[i];
				hi_level[i]  = level[i];
				led_state[i] = (led_thr == 0);
			end
		end else if (ok && rq.command == irsf_pkg::CMD_PRIME) begin
			for (i = 0; i < NWIN; i++)
				win_mem[ch][i] = rq.sample;
			win_total[ch] = 13'(rq.sample * NWIN);
			wr_ptr[ch]    = '0;
			level[ch]     = rq.sample;
			lo_level[ch]  = rq.sample;
			hi_level[ch]  = rq.sample;
			led_state[ch] = (led_thr == 0);
		end else if (ok && rq.command == irsf_pkg::CMD_SAMPLE) begin
			p = wr_ptr[ch];
			win_total[ch] = win_total[ch] - win_mem[ch][p] + rq.sample;
			win_mem[ch][p] = rq.sample;
			wr_ptr[ch] = 3'((p + 1) % NWIN);
			f = win_total[ch] / NWIN;
			level[ch] = irsf_pkg::LVL_W'(f);
			if (f < lo_level[ch])
				lo_level[ch] = irsf_pkg::LVL_W'(f);
			if (f > hi_level[ch])
				hi_level[ch] = irsf_pkg::LVL_W'(f);
			nrm = scale_level(f, lo_level[ch], hi_level[ch]);
			led_state[ch] = (nrm >= led_thr);
		end
		r.channel_out = rq.channel;
		if (ok) begin
			r.filtered  = level[ch];
			r.min_level = lo_level[ch];
			r.max_level = hi_level[ch];
			r.norm      = irsf_pkg::LVL_W'(nrm);
		end else begin
			r.filtered  = '0;
			r.min_level = '0;
			r.max_level = '0;
			r.norm      = '0;
		end
		r.led_mask = led_state;
		return r;
	endfunction

	// driver: presents queued requests, random gaps, optional drain before a request
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req_now = sensor_req_q.pop_front();
				expected_level_q.push_back(filter_normalize(req_now));
			end
			if (!s_tvalid || s_tready) begin
				if (sensor_req_q.size() != 0)
					req_head = sensor_req_q[0];
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (sensor_req_q.size() == 0 ||
						(req_head.wait_idle && expected_level_q.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 3) == 0) begin
					src_gap = $urandom_range(0, 5);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, req_head.sample, req_head.channel};
					s_tuser  <= req_head.command;
				end
			end
		end
	end

	// monitor: random backpressure and scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_res = {m_tdata[2:0], m_tdata[12:3], m_tdata[22:13], m_tdata[32:23],
					m_tdata[42:33], m_tdata[48:43]};
				if (expected_level_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("ERROR: unexpected result %h at %0t", got_res, $realtime);
				end else begin
					want_res = expected_level_q.pop_front();
					if (got_res.channel_out !== want_res.channel_out ||
						got_res.filtered !== want_res.filtered ||
						got_res.min_level !== want_res.min_level ||
						got_res.max_level !== want_res.max_level ||
						got_res.norm !== want_res.norm ||
						got_res.led_mask !== want_res.led_mask) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"ERROR: ch/filt/min/max/norm/led exp %0d/%0d/%0d/%0d/%0d/%b",
								" got %0d/%0d/%0d/%0d/%0d/%b at %0t"},
								want_res.channel_out, want_res.filtered, want_res.min_level,
								want_res.max_level, want_res.norm, want_res.led_mask,
								got_res.channel_out, got_res.filtered, got_res.min_level,
								got_res.max_level, got_res.norm, got_res.led_mask, $realtime);
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_req(input logic [1:0] cmd, input int ch, input int smp);
		sensor_req_t rq;
		rq.wait_idle = 1'b0;
		rq.command   = cmd;
		rq.channel   = irsf_pkg::CH_W'(ch);
		rq.sample    = irsf_pkg::SMP_W'(smp);
		sensor_req_q.push_back(rq);
	endtask

	task automatic wait_drained();
		while (sensor_req_q.size() != 0 || expected_level_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [irsf_pkg::LVL_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		led_thr = value;
	endtask

	// mostly samples that drift per channel, some primes and recalibrations, a little noise
	task automatic queue_random_req();
		int pick, ch, smp, step;
		sensor_req_t rq;
		pick = $urandom_range(0, 99);
		ch   = $urandom_range(0, NCH - 1);
		if (pick < 3) begin
			rq.command = irsf_pkg::CMD_W'($urandom_range(0, 3));
			rq.channel = irsf_pkg::CH_W'($urandom_range(0, 7));
			rq.sample  = irsf_pkg::SMP_W'($urandom_range(0, 1023));
		end else if (pick < 7) begin
			smp = $urandom_range(0, 1023);
			drift[ch] = smp;
			rq.command = irsf_pkg::CMD_PRIME;
			rq.channel = irsf_pkg::CH_W'(ch);
			rq.sample  = irsf_pkg::SMP_W'(smp);
		end else if (pick < 9) begin
			rq.command = irsf_pkg::CMD_RECAL;
			rq.channel = irsf_pkg::CH_W'($urandom_range(0, 7));
			rq.sample  = irsf_pkg::SMP_W'($urandom_range(0, 1023));
		end else begin
			step = $urandom_range(0, 160);
			drift[ch] = drift[ch] + step - 80;
			if (drift[ch] < 0)
				drift[ch] = 0;
			if (drift[ch] > 1023)
				drift[ch] = 1023;
			case ($urandom_range(0, 9))
				0:       smp = $urandom_range(0, 1023);
				1:       smp = $urandom_range(0, 1) * 1023;
				default: smp = drift[ch];
			endcase
			rq.command = irsf_pkg::CMD_SAMPLE;
			rq.channel = irsf_pkg::CH_W'(ch);
			rq.sample  = irsf_pkg::SMP_W'(smp);
		end
		rq.wait_idle = ($urandom_range(0, 49) == 0);
		sensor_req_q.push_back(rq);
	endtask

	task automatic run_phase(input int n);
		for (int k = 0; k < n; k++) begin
			queue_random_req();
			while (sensor_req_q.size() > 16)
				@(posedge clk);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, threshold at its reset value
		queue_req(irsf_pkg::CMD_SAMPLE, 0, 1023);   // empty window, full-scale norm
		queue_req(irsf_pkg::CMD_SAMPLE, 0, 0);
		queue_req(irsf_pkg::CMD_PRIME, 1, 0);
		queue_req(irsf_pkg::CMD_PRIME, 2, 1023);
		queue_req(irsf_pkg::CMD_SAMPLE, 2, 0);
		queue_req(irsf_pkg::CMD_SAMPLE, 2, 1023);
		queue_req(irsf_pkg::CMD_SAMPLE, 5, 'h2AA);
		queue_req(irsf_pkg::CMD_SAMPLE, 5, 'h155);
		queue_req(irsf_pkg::CMD_SAMPLE, 6, 1023);   // channel out of range
		queue_req(irsf_pkg::CMD_PRIME, 7, 512);
		queue_req(CMD_UNDEF, 2, 100);
		queue_req(CMD_UNDEF, 7, 0);
		queue_req(irsf_pkg::CMD_RECAL, 3, 0);
		queue_req(irsf_pkg::CMD_SAMPLE, 2, 0);
		queue_req(irsf_pkg::CMD_SAMPLE, 3, 1023);
		queue_req(irsf_pkg::CMD_RECAL, 6, 1023);    // recal from an invalid channel still hits all
		queue_req(irsf_pkg::CMD_PRIME, 5, 1023);
		for (int k = 0; k < 8; k++)                 // wrap the write pointer of one channel
			queue_req(irsf_pkg::CMD_SAMPLE, 4, 100 + k * 130);

		write_threshold('0);
		run_phase(PHASE_ITEMS);
		write_threshold(irsf_pkg::LVL_W'(irsf_pkg::NORM_FULL));
		idle_on = 1'b0;
		run_phase(PHASE_ITEMS);
		write_threshold(irsf_pkg::LVL_W'($urandom_range(1, 999)));
		idle_on = 1'b1;
		run_phase(PHASE_ITEMS);
		write_threshold(irsf_pkg::LVL_W'($urandom_range(0, 1000)));
		run_phase(PHASE_ITEMS / 2);
		idle_on = 1'b0;
		run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

		wait_drained();
		if (mismatch_cnt == 0 && expected_level_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
